@@ src/bfsm_pkg.sv @@
// Shared types, constants and codes for the bloom filter string membership block.
// Depends on nothing; the queue, front, back, top level and testbench files import it.
package bfsm_pkg;

   localparam int MAX_BYTES  = 4096;
   localparam int MAX_HASHES = 16;
   localparam int HASH_W     = 64;
   localparam int ADDR_W     = $clog2(MAX_BYTES);
   localparam int MOD_W      = $clog2(MAX_BYTES * 8) + 1;
   localparam int SIZE_W     = 13;
   localparam int COUNT_W    = 5;
   localparam int IDX_W      = $clog2(MAX_HASHES);
   localparam int STEP_W     = $clog2(HASH_W);
   localparam int CSR_W      = 13;
   localparam int CSR_IDX_W  = 1;

   localparam logic [HASH_W-1:0]    DJB2_INIT      = 64'd5381;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_BYTES = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HASH_COUNT = 1'd1;
   localparam logic                 OP_INSERT      = 1'b0;

   // One finished string handed from the hash front to the probe back
   typedef struct packed {
      logic [HASH_W-1:0] djb2;
      logic [HASH_W-1:0] sdbm;
      logic              op;
   } job_type;

   typedef struct packed {
      logic [SIZE_W-1:0]  size_bytes;
      logic [COUNT_W-1:0] hash_count;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_READ,
      ST_UPDATE
   } back_state_type;

endpackage

@@ src/bfsm_if.sv @@
// Valid/ready channel interfaces for request and response items.
// Depends on nothing.
interface bfsm_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] char_byte;
   logic       last;
   modport source (output valid, operation, char_byte, last, input ready);
   modport sink   (input valid, operation, char_byte, last, output ready);
endinterface

interface bfsm_rsp_if;
   logic valid;
   logic ready;
   logic probably_member;
   logic was_query;
   modport source (output valid, probably_member, was_query, input ready);
   modport sink   (input valid, probably_member, was_query, output ready);
endinterface

@@ src/bfsm_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module bfsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ src/bfsm_queue.sv @@
// Two-entry job queue between the hash front and the probe back.
// Depends on bfsm_pkg.
module bfsm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bfsm_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output bfsm_pkg::job_type head_job
);
   import bfsm_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign full      = count_ff == 2'd2;
   assign not_empty = count_ff != 2'd0;
   assign head_job  = entry_ff[rd_ptr_ff];
endmodule

@@ src/bfsm_front.sv @@
// Hash front: runs djb2 and sdbm over accepted bytes and emits a job per string.
// Depends on bfsm_pkg and bfsm_if.
module bfsm_front (
   input  logic              clock,
   input  logic              reset,
   bfsm_req_if.sink          req,
   input  logic              enable,
   input  logic              queue_full,
   output logic              push,
   output bfsm_pkg::job_type push_job
);
   import bfsm_pkg::*;

   logic [HASH_W-1:0] djb2_ff, djb2_in;
   logic [HASH_W-1:0] sdbm_ff, sdbm_in;
   logic              ended_ff, ended_in;
   logic [HASH_W-1:0] djb2_next, sdbm_next, c_ext;
   logic              take, hash_on;

   assign req.ready = enable && !queue_full;
   assign take      = req.valid && req.ready;

   // Fold in the byte unless the string already ended or this byte is the zero that ends it
   always_comb begin
      c_ext     = {{(HASH_W-8){1'b0}}, req.char_byte};
      hash_on   = !ended_ff && (req.char_byte != 8'd0);
      djb2_next = djb2_ff;
      sdbm_next = sdbm_ff;
      if (hash_on) begin
         djb2_next = (djb2_ff << 5) + djb2_ff + c_ext;
         sdbm_next = c_ext + (sdbm_ff << 6) + (sdbm_ff << 16) - sdbm_ff;
      end
      djb2_in  = djb2_ff;
      sdbm_in  = sdbm_ff;
      ended_in = ended_ff;
      if (take) begin
         if (req.last) begin
            djb2_in  = DJB2_INIT;
            sdbm_in  = '0;
            ended_in = 1'b0;
         end else begin
            djb2_in  = djb2_next;
            sdbm_in  = sdbm_next;
            ended_in = ended_ff || (req.char_byte == 8'd0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         djb2_ff  <= DJB2_INIT;
         sdbm_ff  <= '0;
         ended_ff <= 1'b0;
      end else begin
         djb2_ff  <= djb2_in;
         sdbm_ff  <= sdbm_in;
         ended_ff <= ended_in;
      end
   end

   assign push          = take && req.last;
   assign push_job.djb2 = djb2_next;
   assign push_job.sdbm = sdbm_next;
   assign push_job.op   = req.operation;
endmodule

@@ src/bfsm_back.sv @@
// Probe back: forms each 64-bit probe sum, reduces it modulo the bit count, then sets or tests it.
// Depends on bfsm_pkg, bfsm_if and bfsm_ram.
module bfsm_back (
   input  logic              clock,
   input  logic              reset,
   input  bfsm_pkg::cfg_type cfg,
   input  logic              job_valid,
   input  bfsm_pkg::job_type job,
   output logic              job_pop,
   output logic              cleared,
   bfsm_rsp_if.source        rsp
);
   import bfsm_pkg::*;

   back_state_type     state_ff, state_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [HASH_W-1:0]  sum_ff, sum_in, sdbm_ff, sdbm_in, sh_ff, sh_in;
   logic [STEP_W-1:0]  d_ff, d_in;
   logic [MOD_W-1:0]   m_ff, m_in, rem_ff, rem_in, r_ff, r_in;
   logic [COUNT_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               op_ff, op_in, all_ff, all_in;
   logic               rv_ff, rv_in, pm_ff, pm_in, wq_ff, wq_in;
   logic [SIZE_W-1:0]  size_used;
   logic [COUNT_W-1:0] k_used;
   logic [MOD_W:0]     dt;
   logic [MOD_W-1:0]   rem_step;
   logic [HASH_W-1:0]  sum_next;
   logic [7:0]         rd_data, mask, wr_data;
   logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
   logic               ram_we, hit;

   bfsm_ram #(.WIDTH(8), .DEPTH(MAX_BYTES)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (wr_data),
      .rd_addr (ram_raddr),
      .rd_data (rd_data)
   );

   // Clamp configuration
   always_comb begin
      if (cfg.size_bytes == '0) begin
         size_used = SIZE_W'(1);
      end else if (cfg.size_bytes > SIZE_W'(MAX_BYTES)) begin
         size_used = SIZE_W'(MAX_BYTES);
      end else begin
         size_used = cfg.size_bytes;
      end
      k_used = (cfg.hash_count > COUNT_W'(MAX_HASHES)) ? COUNT_W'(MAX_HASHES)
                                                       : cfg.hash_count;
   end

   // One restoring remainder step, and the wrapped sum of the next probe
   always_comb begin
      dt       = {rem_ff, sh_ff[HASH_W-1]};
      rem_step = (dt >= {1'b0, m_ff}) ? MOD_W'(dt - {1'b0, m_ff}) : MOD_W'(dt);
      sum_next = sum_ff + sdbm_ff + {{(HASH_W-STEP_W){1'b0}}, d_ff};
      mask     = 8'h80 >> r_ff[2:0];
      hit      = (rd_data & mask) != 8'd0;
   end

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      step_in     = step_ff;
      sum_in      = sum_ff;
      sdbm_in     = sdbm_ff;
      sh_in       = sh_ff;
      d_in        = d_ff;
      m_in        = m_ff;
      rem_in      = rem_ff;
      r_in        = r_ff;
      k_in        = k_ff;
      idx_in      = idx_ff;
      op_in       = op_ff;
      all_in      = all_ff;
      rv_in       = rv_ff && !rsp.ready;
      pm_in       = pm_ff;
      wq_in       = wq_ff;
      job_pop     = 1'b0;
      ram_we      = 1'b0;
      ram_waddr   = r_ff[ADDR_W+2:3];
      ram_raddr   = r_ff[ADDR_W+2:3];
      wr_data     = rd_data | mask;
      case (state_ff)
         ST_CLEAR: begin
            // Zero one byte a cycle
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            wr_data     = 8'd0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(MAX_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // Take a job once the previous result is gone
            if (job_valid && !rv_ff) begin
               job_pop = 1'b1;
               sum_in  = job.djb2;
               sh_in   = job.djb2;
               sdbm_in = job.sdbm;
               op_in   = job.op;
               m_in    = {size_used, 3'b000};
               k_in    = k_used;
               rem_in  = '0;
               step_in = '0;
               d_in    = STEP_W'(1);
               idx_in  = '0;
               all_in  = 1'b1;
               if (k_used == '0) begin
                  // No probes: answer at once
                  rv_in = 1'b1;
                  pm_in = 1'b1;
                  wq_in = job.op;
               end else begin
                  state_in = ST_MOD;
               end
            end
         end
         ST_MOD: begin
            rem_in  = rem_step;
            sh_in   = sh_ff << 1;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(HASH_W - 1)) begin
               r_in     = rem_step;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            // Set or test the probed bit, then start reducing the next probe sum, or answer after the last probe
            ram_we  = (op_ff == OP_INSERT);
            all_in  = all_ff && hit;
            idx_in  = idx_ff + IDX_W'(1);
            sum_in  = sum_next;
            sh_in   = sum_next;
            d_in    = d_ff + STEP_W'(2);
            rem_in  = '0;
            step_in = '0;
            if ({1'b0, idx_ff} == k_ff - COUNT_W'(1)) begin
               rv_in    = 1'b1;
               pm_in    = (op_ff == OP_INSERT) ? 1'b1 : (all_ff && hit);
               wq_in    = op_ff;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_MOD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         rv_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         rv_ff       <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      sum_ff  <= sum_in;
      sdbm_ff <= sdbm_in;
      sh_ff   <= sh_in;
      d_ff    <= d_in;
      m_ff    <= m_in;
      rem_ff  <= rem_in;
      r_ff    <= r_in;
      k_ff    <= k_in;
      idx_ff  <= idx_in;
      op_ff   <= op_in;
      all_ff  <= all_in;
      pm_ff   <= pm_in;
      wq_ff   <= wq_in;
   end

   assign cleared             = state_ff != ST_CLEAR;
   assign rsp.valid           = rv_ff;
   assign rsp.probably_member = pm_ff;
   assign rsp.was_query       = wq_ff;
endmodule

@@ src/bloom_filter_string_membership.sv @@
// Top level of the bloom filter string membership block.
// Depends on bfsm_pkg, bfsm_if, bfsm_front, bfsm_queue and bfsm_back.
//
// Usage:
//   req_bus carries one string byte per item with operation and last. Bytes
//   are taken one per cycle while ready is high. A zero byte ends hashing;
//   bytes after it up to last are ignored. Only the operation on the last item counts.
//   rsp_bus returns one item per string: was_query echoes the operation,
//   probably_member is the query answer (always 1 for an insert).
//   csr_we/csr_index/csr_wdata write size_bytes (index 0) and hash_count
//   (index 1); write only while no string is in flight.
// Timing:
//   The last byte enters a two-entry job queue. For each of the K probes the
//   probe unit reduces the 64-bit probe sum modulo 8*size_bytes one bit a
//   cycle, then reads and writes the bit store in ST_READ and ST_UPDATE. The
//   probe unit takes a waiting job in the cycle after the previous result
//   is taken. The queue lets the next two strings hash meanwhile; a full
//   queue drops req_bus.ready.
// Reset: the 4096-byte bit store is cleared one byte a cycle, with
//   req_bus.ready low. A stalled response holds the probe unit, which
//   starts no new job until its result is taken.
module bloom_filter_string_membership (
   input  logic                               clock,
   input  logic                               reset,
   bfsm_req_if.sink                           req_bus,
   bfsm_rsp_if.source                         rsp_bus,
   input  logic                               csr_we,
   input  logic [bfsm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bfsm_pkg::CSR_W-1:0]         csr_wdata
);
   import bfsm_pkg::*;

   cfg_type cfg_ff, cfg_in;
   job_type push_job, head_job;
   logic    push, pop, q_full, q_not_empty, cleared;

   // Write configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SIZE_BYTES: cfg_in.size_bytes = csr_wdata[SIZE_W-1:0];
            CSR_HASH_COUNT: cfg_in.hash_count = csr_wdata[COUNT_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.size_bytes <= SIZE_W'(4096);
         cfg_ff.hash_count <= COUNT_W'(3);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bfsm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .enable     (cleared),
      .queue_full (q_full),
      .push       (push),
      .push_job   (push_job)
   );

   bfsm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_not_empty),
      .head_job  (head_job)
   );

   bfsm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (q_not_empty),
      .job       (head_job),
      .job_pop   (pop),
      .cleared   (cleared),
      .rsp       (rsp_bus)
   );
endmodule

@@ src/bfsm_checker.sv @@
// Port-level checker for the bloom filter string membership block, with its bind.
// Depends on bloom_filter_string_membership.
module bfsm_port_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_probably_member,
   input logic rsp_was_query
);
   // Clearing pass keeps the request side closed right after reset
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request accepted during clearing pass");

   // No response right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Insert answers are always one
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_was_query) |-> rsp_probably_member)
      else $error("insert reported non-member");

   // Stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_probably_member)
                                     && $stable(rsp_was_query)))
      else $error("stalled response changed");
endmodule

bind bloom_filter_string_membership bfsm_port_checker u_bfsm_port_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_bus.valid),
   .req_ready           (req_bus.ready),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .rsp_probably_member (rsp_bus.probably_member),
   .rsp_was_query       (rsp_bus.was_query)
);

@@ tb/sv/bfsm_checker.sv @@
// Checker for the bloom filter string membership block: watches the request,
// response and register write ports, predicts each answer and compares.
// Depends on bfsm_pkg and the channel interfaces in bfsm_if.
module bfsm_checker
   import bfsm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   bfsm_req_if                  req,
   bfsm_rsp_if                  rsp,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output int                   failures,
   output int                   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic probably_member;
      logic was_query;
   } answer_type;

   answer_type        answers_due[$];
   logic [HASH_W-1:0] djb2_sum;
   logic [HASH_W-1:0] sdbm_sum;
   logic              word_done;
   logic [SIZE_W-1:0] size_reg;
   logic [COUNT_W-1:0] count_reg;
   bit                filter_map [0:MAX_BYTES*8-1];

   // Probe the filter for one finished word; set bits on insert
   function automatic answer_type probe_filter(logic op);
      answer_type        ans;
      logic [HASH_W-1:0] modulus, spot, step;
      int                probes;
      modulus = (size_reg == 0) ? 64'd8 :
                (size_reg > MAX_BYTES) ? 64'(MAX_BYTES * 8) : 64'(size_reg) * 8;
      probes = (count_reg > MAX_HASHES) ? MAX_HASHES : int'(count_reg);
      ans.probably_member = 1'b1;
      ans.was_query = op;
      for (int i = 0; i < probes; i++) begin
         step = 64'(i);
         spot = (djb2_sum + step * sdbm_sum + step * step) % modulus;
         if (op == OP_INSERT) filter_map[spot] = 1'b1;
         else if (!filter_map[spot]) ans.probably_member = 1'b0;
      end
      return ans;
   endfunction

   always @(posedge clock) begin
      answer_type got, want;
      if (reset) begin
         answers_due.delete();
         djb2_sum = DJB2_INIT;
         sdbm_sum = '0;
         word_done = 1'b0;
         size_reg = 13'd4096;
         count_reg = 5'd3;
         failures = 0;
         foreach (filter_map[j]) filter_map[j] = 1'b0;
      end else begin
         // Track register writes
         if (csr_we) begin
            if (csr_index == CSR_SIZE_BYTES) size_reg = csr_wdata[SIZE_W-1:0];
            else if (csr_index == CSR_HASH_COUNT) count_reg = csr_wdata[COUNT_W-1:0];
         end
         // Advance the hashes on each accepted byte up to the first zero byte
         if (req.valid && req.ready) begin
            if (!word_done) begin
               if (req.char_byte == 8'd0) word_done = 1'b1;
               else begin
                  djb2_sum = (djb2_sum << 5) + djb2_sum + 64'(req.char_byte);
                  sdbm_sum = 64'(req.char_byte) + (sdbm_sum << 6) + (sdbm_sum << 16)
                             - sdbm_sum;
               end
            end
            if (req.last) begin
               answers_due.push_back(probe_filter(req.operation));
               djb2_sum = DJB2_INIT;
               sdbm_sum = '0;
               word_done = 1'b0;
            end
         end
         // Compare each answer with the oldest one due
         if (rsp.valid && rsp.ready) begin
            got.probably_member = rsp.probably_member;
            got.was_query = rsp.was_query;
            if (answers_due.size() == 0) begin
               $error("unexpected response: probably_member %0b was_query %0b",
                      got.probably_member, got.was_query);
               failures++;
            end else begin
               want = answers_due.pop_front();
               if (got.probably_member !== want.probably_member) begin
                  $error("probably_member expected %0b actual %0b",
                         want.probably_member, got.probably_member);
                  failures++;
               end
               if (got.was_query !== want.was_query) begin
                  $error("was_query expected %0b actual %0b",
                         want.was_query, got.was_query);
                  failures++;
               end
            end
         end
      end
      pending = answers_due.size();
   end

endmodule

@@ tb/sv/bloom_filter_string_membership_test.sv @@
// Testbench top for the bloom filter string membership block: drives byte
// strings and register settings, and gives the verdict from bfsm_checker.
// Depends on bfsm_pkg, bfsm_if, bfsm_checker and the block itself.
module bloom_filter_string_membership_test;
   import bfsm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT  = 20000;
   localparam int DRAIN_WAIT  = 200;

   // A stored word: up to eight bytes, first byte in the low bits
   typedef struct packed {
      logic [3:0]  len;
      logic [63:0] bytes;
   } word_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;
   int                   failures;
   int                   pending;
   bit                   quiet;
   int                   idle_cycles;
   int                   words_sent;
   int                   settings_used;
   word_type             inserted[$];

   bfsm_req_if req ();
   bfsm_rsp_if rsp ();

   bloom_filter_string_membership i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req),
      .rsp_bus   (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bfsm_checker i_checker (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .failures  (failures),
      .pending   (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stall the response side in random bursts, none in the quiet part
   initial begin
      int hold;
      hold = 0;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
            rsp.ready = 1'b0;
         end else if (!quiet && $urandom_range(0, 11) == 0) begin
            hold = $urandom_range(0, 12);
            rsp.ready = 1'b0;
         end else begin
            rsp.ready = 1'b1;
         end
      end
   end

   // End the run when nothing moves for too long
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // Send one byte; called at a falling edge, returns at a falling edge once the byte is taken
   task automatic push_byte(logic op, logic [7:0] c, logic lst);
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req.valid = 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req.valid = 1'b1;
      req.operation = op;
      req.char_byte = c;
      req.last = lst;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
   endtask

   // Send a word; the operation on inner bytes is noise
   task automatic push_word(logic op, word_type w);
      for (int j = 0; j < w.len; j++)
         push_byte((j == w.len - 1) ? op : 1'($urandom), w.bytes[8*j +: 8],
                   j == w.len - 1);
      words_sent++;
   endtask

   // Drain all answers, let the probe unit settle, then write both registers
   task automatic set_filter(logic [CSR_W-1:0] size_val, logic [CSR_W-1:0] count_val);
      req.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
      csr_we = 1'b1;
      csr_index = CSR_SIZE_BYTES;
      csr_wdata = size_val;
      @(negedge clock);
      csr_index = CSR_HASH_COUNT;
      csr_wdata = count_val;
      @(negedge clock);
      csr_we = 1'b0;
      inserted.delete();
      settings_used++;
   endtask

   function automatic word_type random_word();
      word_type w;
      w.len = (($urandom_range(0, 9) == 0) ? 4'd1 : 4'($urandom_range(1, 8)));
      for (int j = 0; j < 8; j++)
         w.bytes[8*j +: 8] = ($urandom_range(0, 11) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      return w;
   endfunction

   // Inserts of fresh words mixed with queries of stored words and of fresh ones
   task automatic random_words(int byte_budget);
      word_type w;
      int       sent;
      sent = 0;
      while (sent < byte_budget) begin
         if (inserted.size() > 0 && $urandom_range(0, 2) == 0) begin
            w = inserted[$urandom_range(0, inserted.size() - 1)];
            push_word(1'b1, w);
         end else if ($urandom_range(0, 1) == 0) begin
            w = random_word();
            push_word(1'b1, w);
         end else begin
            w = random_word();
            push_word(1'b0, w);
            if (inserted.size() < 64) inserted.push_back(w);
         end
         sent += w.len;
         // Let the pipeline empty once in a while
         if ($urandom_range(0, 60) == 0) begin
            req.valid = 1'b0;
            while (pending != 0) @(negedge clock);
         end
      end
   endtask

   initial begin
      word_type w;
      quiet = 1'b0;
      words_sent = 0;
      settings_used = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_SIZE_BYTES;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.operation = 1'b0;
      req.char_byte = 8'd0;
      req.last = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed words under the reset settings
      w = '{len: 4'd1, bytes: 64'h00};          // empty word, query
      push_word(1'b1, w);
      w = '{len: 4'd1, bytes: 64'h61};          // insert then query one byte
      push_word(1'b0, w);
      push_word(1'b1, w);
      w = '{len: 4'd2, bytes: 64'h6261};        // never inserted
      push_word(1'b1, w);
      w = '{len: 4'd3, bytes: 64'hFF_FF_FF};    // top byte values
      push_word(1'b0, w);
      push_word(1'b1, w);
      w = '{len: 4'd4, bytes: 64'h55_AA_00_41}; // zero in the middle ends hashing
      push_word(1'b1, w);                       // hashes as the single byte 0x41
      w = '{len: 4'd1, bytes: 64'h41};
      push_word(1'b0, w);
      w = '{len: 4'd4, bytes: 64'h55_AA_00_41};
      push_word(1'b1, w);
      w = '{len: 4'd2, bytes: 64'h00_80};       // final byte zero
      push_word(1'b1, w);
      w = '{len: 4'd1, bytes: 64'h01};
      push_word(1'b1, w);

      // Extremes of both registers, then ordinary settings
      set_filter(13'd1, 13'd1);
      random_words(200);
      set_filter(13'd0, 13'd0);                 // size zero acts as one; no probes
      w = '{len: 4'd2, bytes: 64'h7A7A};
      push_word(1'b0, w);
      push_word(1'b1, w);
      random_words(100);
      set_filter(13'h1FFF, 13'd16);             // size saturates
      random_words(250);
      set_filter(13'd4096, 13'h1FFF);           // count above the maximum
      random_words(250);
      set_filter(13'd3, 13'd7);
      random_words(200);
      set_filter(13'($urandom_range(1, 64)), 13'($urandom_range(1, 16)));
      random_words(200);

      // Last part with no idling on either side
      set_filter(13'd16, 13'd4);
      quiet = 1'b1;
      random_words(200);

      req.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
      $display("Sent %0d words across %0d register settings, inserts and queries mixed.",
               words_sent, settings_used + 1);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/bfsm_pkg.sv
src/bfsm_if.sv
src/bfsm_ram.sv
src/bfsm_queue.sv
src/bfsm_front.sv
src/bfsm_back.sv
src/bloom_filter_string_membership.sv
src/bfsm_checker.sv
tb/sv/bfsm_checker.sv
tb/sv/bloom_filter_string_membership_test.sv
